[hw/rtl/polyline_segment_metrics_defines.svh]
// Assertion helpers shared by the RTL.
`ifndef POLYLINE_SEGMENT_METRICS_DEFINES_SVH
`define POLYLINE_SEGMENT_METRICS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/psm_pkg.sv]
package psm_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int AW  = 72;   // unit datapath width
  localparam int QW  = 51;   // quotient / root register width
  localparam int LW  = 35;   // length width
  localparam int TW  = 48;   // time width
  localparam int CW  = 16;   // cosine width
  localparam int SW  = 6;    // step counter width
  localparam int FRAC_BITS = 15;

  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
  localparam logic [CW-1:0] COS_M1   = 16'h8000;
  localparam logic [CW-1:0] COS_P1   = 16'h7FFF;
  localparam logic [31:0]   FEED_RST = 32'h0001_0000;

  typedef logic [1:0] psm_op_t;
  localparam psm_op_t OP_MAC  = 2'd0;
  localparam psm_op_t OP_MSC  = 2'd1;
  localparam psm_op_t OP_SQRT = 2'd2;
  localparam psm_op_t OP_DIV  = 2'd3;

  typedef struct packed {
    psm_op_t         op;
    logic [SW-1:0]   steps;
    logic [AW-1:0]   r0;
    logic [AW-1:0]   x0;
    logic [AW-1:0]   d;
  } psm_req_t;

endpackage

[hw/rtl/psm_unit.sv]
`include "polyline_segment_metrics_defines.svh"

module psm_unit
  import psm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  psm_req_t       req,
  output logic           done,
  output logic [AW-1:0]  acc,
  output logic [QW-1:0]  q
);

  logic [AW-1:0] acc_r, acc_nxt, sh_r, sh_nxt, d_r;
  logic [QW-1:0] q_r, q_nxt;
  psm_op_t       op_r;
  logic [SW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [AW-1:0] opa, opb;
  logic          sub, take;
  logic [AW:0]   sum;

  always_comb begin
    opa = acc_r;
    opb = sh_r;
    sub = 1'b0;
    case (op_r)
      OP_MAC: begin
        sub = 1'b0;
      end
      OP_MSC: begin
        sub = 1'b1;
      end
      OP_SQRT: begin
        opa = {acc_r[AW-3:0], sh_r[AW-1:AW-2]};
        opb = {{(AW-QW-2){1'b0}}, q_r, 2'b01};
        sub = 1'b1;
      end
      default: begin
        opa = {acc_r[AW-2:0], sh_r[AW-1]};
        opb = d_r;
        sub = 1'b1;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, opb ^ {AW{sub}}} + {{AW{1'b0}}, sub};
    if (op_r == OP_MAC || op_r == OP_MSC) begin
      take   = q_r[0];
      q_nxt  = q_r >> 1;
      sh_nxt = sh_r << 1;
    end else begin
      take   = sum[AW];
      q_nxt  = {q_r[QW-2:0], take};
      sh_nxt = (op_r == OP_SQRT) ? (sh_r << 2) : (sh_r << 1);
    end
    acc_nxt = take ? sum[AW-1:0] : opa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= req.op;
      acc_r <= req.r0;
      sh_r  <= req.x0;
      d_r   <= req.d;
      q_r   <= (req.op == OP_MAC || req.op == OP_MSC) ? req.d[QW-1:0] : '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign q    = q_r;

  `PSM_ASSERT_NOW(a_no_restart, start, !busy_r)
  `PSM_ASSERT_NOW(a_done_idle, done_r, !busy_r)
  `PSM_ASSERT_NEXT(a_done_after_last, busy_r && cnt_r == SW'(1) && !start, done_r)

endmodule

[hw/rtl/polyline_segment_metrics.sv]
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_point_x/y/z, in_last_point
// out     | out | out_valid / out_ready | out_segment_length, _time, _corner_cosine, _last_of_run
// cfg     | in  | cfg_wr_en             | cfg_wr_data (feed speed)
//
// One word at a time; ready only while the sequencer is idle. An op on the unit is a start,
// its steps and a done strobe. An interior point next to a zero-length segment skips the
// cosine ops, and a closing point adds a time divide for its own word.
// Synchronous active-low reset clears the path and sets feed speed to 1.0.
// A held result on out stalls the sequencer only when the next one is ready.
`include "polyline_segment_metrics_defines.svh"

module polyline_segment_metrics
  import psm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  input  logic                 in_last_point,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LW-1:0]        out_segment_length,
  output logic [TW-1:0]        out_segment_time,
  output logic signed [CW-1:0] out_corner_cosine,
  output logic                 out_last_of_run,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);

  localparam int DW = COORD_BITS + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_DOT  = 4'd3;
  localparam logic [3:0] S_NEG  = 4'd4;
  localparam logic [3:0] S_DEN  = 4'd5;
  localparam logic [3:0] S_COS  = 4'd6;
  localparam logic [3:0] S_T1   = 4'd7;
  localparam logic [3:0] S_E1   = 4'd8;
  localparam logic [3:0] S_T2   = 4'd9;
  localparam logic [3:0] S_E2   = 4'd10;

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_TWO  = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ps_r, ps_nxt, k_r, k_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [31:0] feed_r;

  logic signed [COORD_BITS-1:0] cur_r[3], prev_r[3], old_r[3];
  logic          last_r;
  logic [LW-1:0] prev_len_r, len_r, len_nxt;
  logic [AW-1:0] num_r, den_r;
  logic          neg_r;
  logic [CW-1:0] cos_r, cos_nxt;
  logic [TW-1:0] t_r, t_nxt;

  logic [LW-1:0] res_len_r, res_len_nxt;
  logic [TW-1:0] res_t_r, res_t_nxt;
  logic [CW-1:0] res_cos_r, res_cos_nxt;
  logic          res_last_r, res_last_nxt;

  logic [LW-1:0] o_len_r;
  logic [TW-1:0] o_t_r;
  logic [CW-1:0] o_cos_r;
  logic          o_last_r;

  logic          in_acc, out_free, load_out, shift_pts, take_in;
  logic signed [DW-1:0] d1, d2;
  logic [DW-1:0] m1, m2;
  logic [LW-1:0] tlen;
  logic [TW-1:0] tq;
  logic [CW-1:0] cq;

  psm_req_t      req;
  logic          u_start, u_done;
  logic [AW-1:0] u_acc;
  logic [QW-1:0] u_q;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign d2 = {cur_r[k_r][COORD_BITS-1], cur_r[k_r]} - {prev_r[k_r][COORD_BITS-1], prev_r[k_r]};
  assign d1 = {old_r[k_r][COORD_BITS-1], old_r[k_r]} - {prev_r[k_r][COORD_BITS-1], prev_r[k_r]};
  assign m2 = d2[DW-1] ? DW'(-d2) : DW'(d2);
  assign m1 = d1[DW-1] ? DW'(-d1) : DW'(d1);
  assign tlen = (state_r == S_T2) ? len_r : prev_len_r;
  assign tq = (|u_q[QW-1:TW]) ? TIME_MAX : u_q[TW-1:0];
  assign cq = neg_r ? (CW'(0) - {1'b0, u_q[FRAC_BITS-1:0]}) : {1'b0, u_q[FRAC_BITS-1:0]};

  always_comb begin
    req.op    = OP_MAC;
    req.steps = SW'(LW);
    req.r0    = '0;
    req.x0    = '0;
    req.d     = '0;
    case (state_r)
      S_SQ: begin
        req.r0 = (k_r == 2'd0) ? '0 : u_acc;
        req.x0 = AW'(m2);
        req.d  = AW'(m2);
      end
      S_SQRT: begin
        req.op = OP_SQRT;
        req.x0 = {u_acc[AW-3:0], 2'b00};
      end
      S_DOT: begin
        req.op = (d1[DW-1] != d2[DW-1]) ? OP_MSC : OP_MAC;
        req.r0 = (k_r == 2'd0) ? '0 : u_acc;
        req.x0 = AW'(m1);
        req.d  = AW'(m2);
      end
      S_DEN: begin
        req.x0 = AW'(prev_len_r);
        req.d  = AW'(len_r);
      end
      S_COS: begin
        req.op    = OP_DIV;
        req.steps = SW'(FRAC_BITS);
        req.r0    = num_r;
        req.d     = den_r;
      end
      S_T1, S_T2: begin
        req.op    = OP_DIV;
        req.steps = SW'(QW);
        req.x0    = {tlen, {(AW-LW){1'b0}}};
        req.d     = AW'(feed_r);
      end
      default: begin
        req.op = OP_MAC;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ps_nxt        = ps_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    u_start       = 1'b0;
    len_nxt       = len_r;
    cos_nxt       = cos_r;
    t_nxt         = t_r;
    res_len_nxt   = res_len_r;
    res_t_nxt     = res_t_r;
    res_cos_nxt   = res_cos_r;
    res_last_nxt  = res_last_r;
    load_out      = 1'b0;
    shift_pts     = 1'b0;
    take_in       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (ps_r == PS_NONE) begin
            if (in_last_point) begin
              res_len_nxt  = '0;
              res_t_nxt    = '0;
              res_cos_nxt  = COS_M1;
              res_last_nxt = 1'b1;
              state_nxt    = S_E2;
            end else begin
              take_in = 1'b1;
              ps_nxt  = PS_ONE;
            end
          end else begin
            k_nxt     = 2'd0;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ, S_DOT: begin
        if (!pend_r) begin
          u_start  = 1'b1;
          pend_nxt = 1'b1;
        end else if (u_done) begin
          pend_nxt = 1'b0;
          k_nxt    = k_r + 2'd1;
          if (k_r == 2'd2) begin
            k_nxt     = 2'd0;
            state_nxt = (state_r == S_SQ) ? S_SQRT : S_NEG;
          end
        end
      end
      S_SQRT: begin
        if (!pend_r) begin
          u_start  = 1'b1;
          pend_nxt = 1'b1;
        end else if (u_done) begin
          pend_nxt = 1'b0;
          len_nxt  = u_q[LW-1:0];
          if (ps_r == PS_ONE) begin
            res_len_nxt  = '0;
            res_t_nxt    = '0;
            res_cos_nxt  = COS_M1;
            res_last_nxt = 1'b0;
            state_nxt    = S_E1;
          end else if (prev_len_r == '0 || u_q[LW-1:0] == '0) begin
            cos_nxt   = '0;
            state_nxt = S_T1;
          end else begin
            k_nxt     = 2'd0;
            state_nxt = S_DOT;
          end
        end
      end
      S_NEG: begin
        state_nxt = S_DEN;
      end
      S_DEN: begin
        if (!pend_r) begin
          u_start  = 1'b1;
          pend_nxt = 1'b1;
        end else if (u_done) begin
          pend_nxt  = 1'b0;
          state_nxt = S_COS;
        end
      end
      S_COS: begin
        if (!pend_r) begin
          if (num_r >= den_r) begin
            cos_nxt   = neg_r ? COS_M1 : COS_P1;
            state_nxt = S_T1;
          end else begin
            u_start  = 1'b1;
            pend_nxt = 1'b1;
          end
        end else if (u_done) begin
          pend_nxt  = 1'b0;
          cos_nxt   = cq;
          state_nxt = S_T1;
        end
      end
      S_T1, S_T2: begin
        if (!pend_r) begin
          if (feed_r == '0) begin
            t_nxt = TIME_MAX;
            state_nxt = (state_r == S_T1) ? S_E1 : S_E2;
          end else begin
            u_start  = 1'b1;
            pend_nxt = 1'b1;
          end
        end else if (u_done) begin
          pend_nxt  = 1'b0;
          t_nxt     = tq;
          state_nxt = (state_r == S_T1) ? S_E1 : S_E2;
        end
        if (state_nxt != state_r) begin
          res_len_nxt  = tlen;
          res_t_nxt    = t_nxt;
          res_cos_nxt  = (state_r == S_T1) ? cos_nxt : COS_M1;
          res_last_nxt = (state_r == S_T2);
        end
      end
      S_E1: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (last_r) begin
            state_nxt = S_T2;
          end else begin
            shift_pts = 1'b1;
            ps_nxt    = PS_TWO;
            state_nxt = S_IDLE;
          end
        end
      end
      S_E2: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          ps_nxt        = PS_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ps_r        <= PS_NONE;
      k_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      feed_r      <= FEED_RST;
    end else begin
      state_r     <= state_nxt;
      ps_r        <= ps_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        feed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    cos_r      <= cos_nxt;
    t_r        <= t_nxt;
    res_len_r  <= res_len_nxt;
    res_t_r    <= res_t_nxt;
    res_cos_r  <= res_cos_nxt;
    res_last_r <= res_last_nxt;
    if (in_acc) begin
      cur_r[0] <= in_point_x[COORD_BITS-1:0];
      cur_r[1] <= in_point_y[COORD_BITS-1:0];
      cur_r[2] <= in_point_z[COORD_BITS-1:0];
      last_r   <= in_last_point;
    end
    if (take_in) begin
      prev_r[0] <= in_point_x[COORD_BITS-1:0];
      prev_r[1] <= in_point_y[COORD_BITS-1:0];
      prev_r[2] <= in_point_z[COORD_BITS-1:0];
    end
    if (shift_pts) begin
      old_r      <= prev_r;
      prev_r     <= cur_r;
      prev_len_r <= len_r;
    end
    if (state_r == S_NEG) begin
      neg_r <= u_acc[AW-1];
      num_r <= u_acc[AW-1] ? (AW'(0) - u_acc) : u_acc;
    end
    if (state_r == S_DEN && u_done) begin
      den_r <= u_acc;
    end
    if (load_out) begin
      o_len_r  <= res_len_r;
      o_t_r    <= res_t_r;
      o_cos_r  <= res_cos_r;
      o_last_r <= res_last_r;
    end
  end

  psm_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .req   (req),
    .done  (u_done),
    .acc   (u_acc),
    .q     (u_q)
  );

  assign out_valid          = out_valid_r;
  assign out_segment_length = o_len_r;
  assign out_segment_time   = o_t_r;
  assign out_corner_cosine  = o_cos_r;
  assign out_last_of_run    = o_last_r;

  `PSM_ASSERT_NOW(a_ps_range, 1'b1, ps_r != 2'd3)
  `PSM_ASSERT_NOW(a_root_fits, state_r == S_SQRT && u_done, u_q[QW-1:LW] == '0)
  `PSM_ASSERT_NOW(a_pend_op, pend_r,
                  state_r == S_SQ || state_r == S_SQRT || state_r == S_DOT ||
                  state_r == S_DEN || state_r == S_COS || state_r == S_T1 ||
                  state_r == S_T2)

endmodule

[sim/tb_polyline_segment_metrics.sv]
`timescale 1ns / 1ps

module tb_polyline_segment_metrics;
  import psm_pkg::*;

  typedef logic signed [63:0] vec_t [3];

  typedef struct {
    logic [LW-1:0] length;
    logic [TW-1:0] seg_time;
    logic [CW-1:0] cosine;
    logic          last;
  } metric_t;

  class metrics_scoreboard;
    metric_t        expected_q[$];
    logic [31:0]    feed;
    vec_t           prv, old;
    logic [LW-1:0]  prv_len;
    int             held;
    int             errors, results, corners, zero_corners;

    function new();
      feed = FEED_RST;
      errors = 0; results = 0; corners = 0; zero_corners = 0;
      clear_path();
    endfunction

    function void clear_path();
      for (int i = 0; i < 3; i++) begin
        prv[i] = 0;
        old[i] = 0;
      end
      prv_len = 0;
      held = 0;
    endfunction

    function logic [127:0] sq_dist(vec_t a, vec_t b);
      logic [127:0] s, m;
      logic signed [63:0] d;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        d = a[i] - b[i];
        m = d < 0 ? -d : d;
        s += m * m;
      end
      return s;
    endfunction

    function logic [LW-1:0] root(logic [127:0] s);
      logic [127:0] r, t;
      r = 0;
      for (int b = LW - 1; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (s >= t * t) r = t;
      end
      return r[LW-1:0];
    endfunction

    function logic [TW-1:0] time_of(logic [LW-1:0] len);
      logic [63:0] t;
      if (feed == 0) return TIME_MAX;
      t = {len, 16'd0} / feed;
      return t > {16'd0, TIME_MAX} ? TIME_MAX : t[TW-1:0];
    endfunction

    function logic [CW-1:0] corner(vec_t nx);
      logic [127:0] n1, n2, num, den;
      logic signed [127:0] dot, aw, bw;
      logic [16:0] q, q0, frac;
      logic neg;
      n1 = sq_dist(old, prv);
      n2 = sq_dist(nx, prv);
      corners++;
      if (n1 == 0 || n2 == 0) begin
        zero_corners++;
        return 0;
      end
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        aw = old[i] - prv[i];
        bw = nx[i] - prv[i];
        dot += aw * bw;
      end
      den = {93'd0, root(n1)} * {93'd0, root(n2)};
      neg = dot < 0;
      num = neg ? -dot : dot;
      q0 = 0;
      frac = 0;
      while (q0 < 2 && num >= den) begin
        num -= den;
        q0++;
      end
      if (num >= den) q = 17'h10000;
      else begin
        for (int i = 0; i < FRAC_BITS; i++) begin
          num = num << 1;
          frac = frac << 1;
          if (num >= den) begin
            num -= den;
            frac |= 1;
          end
        end
        q = (q0 << 15) | frac;
      end
      if (neg) begin
        if (q > 17'h8000) q = 17'h8000;
        q = 17'h10000 - q;
        return q[15:0];
      end
      return q > 17'h7FFF ? COS_P1 : q[15:0];
    endfunction

    function void push(logic [LW-1:0] len, logic [TW-1:0] tm, logic [CW-1:0] c, logic l);
      metric_t m;
      m.length = len; m.seg_time = tm; m.cosine = c; m.last = l;
      expected_q.push_back(m);
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
      vec_t p;
      logic [LW-1:0] len;
      p[0] = $signed(x); p[1] = $signed(y); p[2] = $signed(z);
      if (held == 0) begin
        if (l) begin
          push(0, 0, COS_M1, 1);
          clear_path();
        end else begin
          prv = p;
          held = 1;
        end
        return;
      end
      if (held == 1) push(0, 0, COS_M1, 0);
      else push(prv_len, time_of(prv_len), corner(p), 0);
      len = root(sq_dist(p, prv));
      if (l) begin
        push(len, time_of(len), COS_M1, 1);
        clear_path();
        return;
      end
      old = prv;
      prv = p;
      prv_len = len;
      held = 2;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h expected %0h (result %0d)", what, got, want, results);
      errors++;
    endtask

    task check(logic [LW-1:0] len, logic [TW-1:0] tm, logic [CW-1:0] c, logic l);
      metric_t m;
      results++;
      if (expected_q.size() == 0) begin
        report("unexpected word", {63'd0, l}, 0);
        return;
      end
      m = expected_q.pop_front();
      if (len !== m.length) report("segment_length", len, m.length);
      if (tm !== m.seg_time) report("segment_time", tm, m.seg_time);
      if (c !== m.cosine) report("corner_cosine", c, m.cosine);
      if (l !== m.last) report("last_of_run", l, m.last);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_last_point;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic out_valid, out_ready;
  logic [LW-1:0] out_segment_length;
  logic [TW-1:0] out_segment_time;
  logic signed [CW-1:0] out_corner_cosine;
  logic out_last_of_run;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  metrics_scoreboard sb;
  bit calm;
  int points_sent;

  polyline_segment_metrics DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_segment_length(out_segment_length), .out_segment_time(out_segment_time),
    .out_corner_cosine(out_corner_cosine), .out_last_of_run(out_last_of_run),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check(out_segment_length, out_segment_time, out_corner_cosine, out_last_of_run);

  initial begin
    int g;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        @(negedge clk) out_ready <= 0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk) in_valid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_point_x <= x; in_point_y <= y; in_point_z <= z; in_last_point <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, z, l);
    points_sent++;
  endtask

  task drain();
    @(negedge clk) in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task write_feed(logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 0;
    sb.feed = v;
  endtask

  function automatic logic [31:0] coord(logic [31:0] prev_c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return prev_c + $signed($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
    if (r < 55) return prev_c;
    if (r < 85) return $urandom();
    if (r < 92) return 32'h8000_0000;
    return 32'h7FFF_FFFF;
  endfunction

  task random_paths(int n);
    logic [31:0] x, y, z;
    int len;
    while (n > 0) begin
      len = $urandom_range(1, 9);
      x = $urandom(); y = $urandom(); z = $urandom();
      for (int i = 0; i < len && n > 0; i++) begin
        x = coord(x); y = coord(y); z = coord(z);
        send_point(x, y, z, i == len - 1 || n == 1 || $urandom_range(0, 49) == 0);
        n--;
      end
    end
  endtask

  initial begin
    logic [31:0] feeds [6];
    sb = new();
    calm = 0;
    points_sent = 0;
    rst_n = 0;
    in_valid = 0; in_point_x = 0; in_point_y = 0; in_point_z = 0; in_last_point = 0;
    cfg_wr_en = 0; cfg_wr_data = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // directed
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1);
    send_point(0, 0, 0, 0);
    send_point(32'h0003_0000, 32'h0004_0000, 0, 1);
    send_point(0, 0, 0, 0);
    send_point(32'h0001_0000, 0, 0, 0);
    send_point(32'h0002_0000, 0, 0, 0);
    send_point(32'h0002_0000, 32'h0001_0000, 0, 0);
    send_point(32'h0001_0000, 0, 0, 0);
    send_point(32'h0001_0000, 0, 0, 0);
    send_point(32'h0001_0000, 0, 32'h0005_0000, 1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1);
    drain();

    feeds[0] = FEED_RST;
    feeds[1] = 32'd1;
    feeds[2] = 32'hFFFF_FFFF;
    feeds[3] = 32'd0;
    feeds[4] = $urandom_range(32'h100, 32'h4_0000);
    feeds[5] = $urandom();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_feed(feeds[ph]);
      calm = (ph == 2);
      random_paths(ph == 0 ? 120 : 76);
      drain();
    end

    $display("%0d points sent over 6 feed speeds, %0d result words checked",
             points_sent, sb.results);
    $display("%0d corners computed, %0d next to a zero-length segment",
             sb.corners, sb.zero_corners);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[polyline_segment_metrics.f]
+incdir+hw/rtl
hw/rtl/psm_pkg.sv
hw/rtl/psm_unit.sv
hw/rtl/polyline_segment_metrics.sv
sim/tb_polyline_segment_metrics.sv
